// File: sv/pfe_pkg.sv
package pfe_pkg;

  // Default sizes of the pipe.
  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned MAX_ENDS  = 255;

  // Fixed widths of the item fields.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 13;
  localparam int unsigned ENDS_W   = 8;
  localparam int unsigned REFS_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_DUP    = 3'd3,
    OP_CLOSE  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EOF         = 3'd1,
    ST_BROKEN_PIPE = 3'd2,
    ST_WOULD_BLOCK = 3'd3,
    ST_BAD_HANDLE  = 3'd4,
    ST_TOO_MANY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the accepted input beat
    logic exec;   // carry out the operation, or set up a read burst
    logic fetch;  // read the ring at the head
    logic send;   // emit one burst byte and prefetch the next
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic burst;      // the held operation is a read that delivers bytes
    logic slot_free;  // the output register can take a result this cycle
    logic last_byte;  // one burst byte remains
  } sts_t;

endpackage

// File: sv/pfe_ctrl.sv
module pfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfe_pkg::sts_t sts_i,
  output pfe_pkg::cmd_t cmd_o
);

  pfe_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pfe_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = pfe_pkg::S_EXEC;
        end
      end
      pfe_pkg::S_EXEC: begin
        // A burst sets up without a result; anything else needs the output slot.
        if (sts_i.burst) begin
          cmd_o.exec = 1'b1;
          state_d    = pfe_pkg::S_FETCH;
        end else if (sts_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = pfe_pkg::S_IDLE;
        end
      end
      pfe_pkg::S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = pfe_pkg::S_SEND;
      end
      pfe_pkg::S_SEND: begin
        if (sts_i.slot_free) begin
          cmd_o.send = 1'b1;
          if (sts_i.last_byte) begin
            state_d = pfe_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = pfe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/pfe_dp.sv
module pfe_dp #(
  parameter int unsigned CAPACITY  = pfe_pkg::CAPACITY,
  parameter int unsigned MAX_BURST = pfe_pkg::MAX_BURST,
  parameter int unsigned MAX_ENDS  = pfe_pkg::MAX_ENDS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfe_pkg::cmd_t                 cmd_i,
  output pfe_pkg::sts_t                 sts_o,
  input  logic [pfe_pkg::OP_W-1:0]      operation_i,
  input  logic [pfe_pkg::LEN_W-1:0]     length_i,
  input  logic [7:0]                    write_byte_i,
  input  logic                          end_reader_i,
  input  logic                          end_writer_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfe_pkg::STATUS_W-1:0]  status_o,
  output logic [7:0]                    read_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [pfe_pkg::FILL_W-1:0]    fill_level_o,
  output logic                          wake_readers_o,
  output logic                          wake_writers_o,
  output logic                          released_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned BW = $clog2(MAX_BURST + 1);
  localparam int unsigned CW = (FW > BW) ? FW : BW;
  localparam int unsigned EW = pfe_pkg::ENDS_W;
  localparam int unsigned RW = pfe_pkg::REFS_W;

  // Held input beat.
  logic [pfe_pkg::OP_W-1:0] op_q, op_d;
  logic [BW-1:0]            len_q, len_d;
  logic [7:0]               wbyte_q, wbyte_d;
  logic                     er_q, er_d, ew_q, ew_d;

  // Pipe state.
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [EW-1:0] readers_q, readers_d;
  logic [EW-1:0] writers_q, writers_d;
  logic [RW-1:0] refs_q, refs_d;
  logic [BW-1:0] remain_q, remain_d;

  // Output register.
  logic                         ovalid_q, ovalid_d;
  logic [pfe_pkg::STATUS_W-1:0] ostatus_q, ostatus_d;
  logic [7:0]                   obyte_q, obyte_d;
  logic                         obvalid_q, obvalid_d;
  logic                         olast_q, olast_d;
  logic [pfe_pkg::FILL_W-1:0]   ofill_q, ofill_d;
  logic                         owr_q, owr_d, oww_q, oww_d, orel_q, orel_d;

  // Ring memory.
  logic [7:0]    ring_mem [CAPACITY];
  logic [7:0]    rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;

  // Helper values.
  logic [AW-1:0] head_inc;
  logic [AW:0]   wsum;
  logic [BW-1:0] burst_n;
  logic [EW-1:0] rd_cl, wr_cl;
  logic [RW-1:0] refs_cl;
  logic          load, burst, slot_free;

  assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
  assign wsum      = {1'b0, head_q} + {1'b0, fill_q[AW-1:0]};
  assign waddr     = (wsum >= (AW + 1)'(CAPACITY)) ? AW'(wsum - (AW + 1)'(CAPACITY))
                                                   : wsum[AW-1:0];
  assign burst_n   = (CW'(len_q) < CW'(fill_q)) ? len_q : BW'(fill_q);
  assign slot_free = !ovalid_q || out_ready_i;
  assign burst     = (op_q == pfe_pkg::OP_READ) && (refs_q != '0) &&
                     (len_q != '0) && (fill_q != '0);

  assign sts_o.burst     = burst;
  assign sts_o.slot_free = slot_free;
  assign sts_o.last_byte = (remain_q == BW'(1));

  // Close arithmetic: end counts stop at zero.
  assign rd_cl   = (er_q && readers_q != '0) ? readers_q - EW'(1) : readers_q;
  assign wr_cl   = (ew_q && writers_q != '0) ? writers_q - EW'(1) : writers_q;
  assign refs_cl = refs_q - RW'(1);

  // Operation decode and next-state logic.
  always_comb begin
    op_d      = op_q;
    len_d     = len_q;
    wbyte_d   = wbyte_q;
    er_d      = er_q;
    ew_d      = ew_q;
    head_d    = head_q;
    fill_d    = fill_q;
    readers_d = readers_q;
    writers_d = writers_q;
    refs_d    = refs_q;
    remain_d  = remain_q;
    ostatus_d = ostatus_q;
    obyte_d   = obyte_q;
    obvalid_d = obvalid_q;
    olast_d   = olast_q;
    ofill_d   = ofill_q;
    owr_d     = owr_q;
    oww_d     = oww_q;
    orel_d    = orel_q;
    we        = 1'b0;
    re        = 1'b0;
    raddr     = head_q;
    load      = 1'b0;

    if (cmd_i.latch) begin
      op_d    = operation_i;
      len_d   = (length_i > pfe_pkg::LEN_W'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(length_i);
      wbyte_d = write_byte_i;
      er_d    = end_reader_i;
      ew_d    = end_writer_i;
    end

    if (cmd_i.exec) begin
      load = !burst;
      // A burst leaves the output register alone, as an earlier result may still wait there.
      if (!burst) begin
        ostatus_d = pfe_pkg::ST_OK;
        obyte_d   = '0;
        obvalid_d = 1'b0;
        olast_d   = 1'b1;
        owr_d     = 1'b0;
        oww_d     = 1'b0;
        orel_d    = 1'b0;
      end
      if (op_q == pfe_pkg::OP_CREATE) begin
        head_d    = '0;
        fill_d    = '0;
        readers_d = EW'(1);
        writers_d = EW'(1);
        refs_d    = RW'(2);
      end else if (refs_q == '0 || op_q > pfe_pkg::OP_CLOSE) begin
        ostatus_d = pfe_pkg::ST_BAD_HANDLE;
      end else if (op_q == pfe_pkg::OP_READ) begin
        if (len_q == '0) begin
          ostatus_d = pfe_pkg::ST_OK;
        end else if (fill_q == '0) begin
          ostatus_d = (writers_q == '0) ? pfe_pkg::ST_EOF : pfe_pkg::ST_WOULD_BLOCK;
        end else begin
          fill_d   = fill_q - FW'(burst_n);
          remain_d = burst_n;
        end
      end else if (op_q == pfe_pkg::OP_WRITE) begin
        if (readers_q == '0) begin
          ostatus_d = pfe_pkg::ST_BROKEN_PIPE;
        end else if (fill_q >= FW'(CAPACITY)) begin
          ostatus_d = pfe_pkg::ST_WOULD_BLOCK;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end else if (op_q == pfe_pkg::OP_DUP) begin
        if ((er_q && readers_q >= EW'(MAX_ENDS)) ||
            (ew_q && writers_q >= EW'(MAX_ENDS)) ||
            (refs_q >= RW'(2 * MAX_ENDS))) begin
          ostatus_d = pfe_pkg::ST_TOO_MANY;
        end else begin
          refs_d = refs_q + RW'(1);
          if (er_q) begin
            readers_d = readers_q + EW'(1);
          end
          if (ew_q) begin
            writers_d = writers_q + EW'(1);
          end
        end
      end else begin
        // Close: release the pipe when the last reference goes.
        refs_d = refs_cl;
        if (refs_cl == '0) begin
          readers_d = '0;
          writers_d = '0;
          head_d    = '0;
          fill_d    = '0;
          orel_d    = 1'b1;
        end else begin
          readers_d = rd_cl;
          writers_d = wr_cl;
          owr_d     = (wr_cl == '0);
          oww_d     = (rd_cl == '0);
        end
      end
      if (!burst) begin
        ofill_d = pfe_pkg::FILL_W'(fill_d);
      end
    end

    if (cmd_i.fetch) begin
      re    = 1'b1;
      raddr = head_q;
    end

    // Emit the prefetched byte and fetch the one after it.
    if (cmd_i.send) begin
      load      = 1'b1;
      re        = 1'b1;
      raddr     = head_inc;
      head_d    = head_inc;
      remain_d  = remain_q - BW'(1);
      ostatus_d = pfe_pkg::ST_OK;
      obyte_d   = rdata_q;
      obvalid_d = 1'b1;
      olast_d   = (remain_q == BW'(1));
      ofill_d   = pfe_pkg::FILL_W'(fill_q);
      owr_d     = 1'b0;
      oww_d     = 1'b0;
      orel_d    = 1'b0;
    end

    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      readers_q <= '0;
      writers_q <= '0;
      refs_q    <= '0;
      remain_q  <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      readers_q <= readers_d;
      writers_q <= writers_d;
      refs_q    <= refs_d;
      remain_q  <= remain_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    len_q     <= len_d;
    wbyte_q   <= wbyte_d;
    er_q      <= er_d;
    ew_q      <= ew_d;
    ostatus_q <= ostatus_d;
    obyte_q   <= obyte_d;
    obvalid_q <= obvalid_d;
    olast_q   <= olast_d;
    ofill_q   <= ofill_d;
    owr_q     <= owr_d;
    oww_q     <= oww_d;
    orel_q    <= orel_d;
  end

  // Ring memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[waddr] <= wbyte_q;
    end
    if (re) begin
      rdata_q <= ring_mem[raddr];
    end
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ostatus_q;
  assign read_byte_o    = obyte_q;
  assign byte_valid_o   = obvalid_q;
  assign last_o         = olast_q;
  assign fill_level_o   = ofill_q;
  assign wake_readers_o = owr_q;
  assign wake_writers_o = oww_q;
  assign released_o     = orel_q;

endmodule

// File: sv/pipe_fifo_with_end_counts.sv
// Byte pipe: a ring FIFO with counts of open reader ends, writer ends and
// references. Each input beat carries one operation (create, read, write,
// dup, close) and is taken when in_valid_i and in_ready_o are both high.
// Results leave on the output channel under out_valid_o / out_ready_i style
// handshaking; every operation gives one result beat, except a read that
// finds data, which gives one beat per delivered byte with last_o on the
// final one.
// Timing: an item is accepted, then executed once the output register is
// free (a read that finds data does not wait for it); a single result is
// registered at execution. A read goes through accept, set-up, one ring
// read, then one byte per cycle, if the receiver is ready, from the single
// read port of the ring memory. One item is in progress at a time; a new
// item is accepted while the previous result waits in the output register.
// Reset clears the counts, the fill level and the control state; the pipe
// is then unused and answers bad_handle until created. The ring contents
// are not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and
// the block waits for it before producing the next result.
module pipe_fifo_with_end_counts #(
  parameter int unsigned CAPACITY  = pfe_pkg::CAPACITY,
  parameter int unsigned MAX_BURST = pfe_pkg::MAX_BURST,
  parameter int unsigned MAX_ENDS  = pfe_pkg::MAX_ENDS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfe_pkg::OP_W-1:0]      operation_i,
  input  logic [pfe_pkg::LEN_W-1:0]     length_i,
  input  logic [7:0]                    write_byte_i,
  input  logic                          end_reader_i,
  input  logic                          end_writer_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfe_pkg::STATUS_W-1:0]  status_o,
  output logic [7:0]                    read_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [pfe_pkg::FILL_W-1:0]    fill_level_o,
  output logic                          wake_readers_o,
  output logic                          wake_writers_o,
  output logic                          released_o
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::sts_t sts;

  // Sequencer.
  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring, counters and output register.
  pfe_dp #(
    .CAPACITY  (CAPACITY),
    .MAX_BURST (MAX_BURST),
    .MAX_ENDS  (MAX_ENDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .length_i       (length_i),
    .write_byte_i   (write_byte_i),
    .end_reader_i   (end_reader_i),
    .end_writer_i   (end_writer_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_byte_o    (read_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .fill_level_o   (fill_level_o),
    .wake_readers_o (wake_readers_o),
    .wake_writers_o (wake_writers_o),
    .released_o     (released_o)
  );

endmodule

// File: sv/pfe_checker.sv
module pfe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [pfe_pkg::STATUS_W-1:0]  status_o,
  input logic [7:0]                    read_byte_o,
  input logic                          byte_valid_o,
  input logic                          last_o,
  input logic [pfe_pkg::FILL_W-1:0]    fill_level_o,
  input logic                          wake_readers_o,
  input logic                          wake_writers_o,
  input logic                          released_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Only one item is in progress: an accepted beat closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted during execution");

  // A delivered byte is always an ok result of a read, without hints.
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      status_o == pfe_pkg::ST_OK && !wake_readers_o && !wake_writers_o && !released_o)
    else $error("byte beat with bad status or close hints");

  // A result without a byte is the only result of its item and carries zero data.
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o && read_byte_o == 8'd0)
    else $error("non-byte result not final or not zero");

  // Release empties the pipe and gives no wake hint.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && released_o |->
      fill_level_o == '0 && !wake_readers_o && !wake_writers_o)
    else $error("release with data or wake hints");

endmodule

bind pipe_fifo_with_end_counts pfe_checker u_pfe_checker (.*);
